### rtl/fpc_pkg.sv
// Shared types, constants and tables for the fly camera update block.
// No dependencies; used by fpc_root_div and first_person_camera_update_unit.
package fpc_pkg;

   // Angles in 1/128 degree
   localparam int unsigned TURN         = 46080;
   localparam int unsigned HALF_TURN    = 23040;
   localparam int unsigned QUARTER_TURN = 11520;
   localparam int unsigned PITCH_LIMIT  = 11392;
   // Offset that keeps yaw + 180 deg + mouse step nonnegative before the wrap
   localparam int unsigned WRAP_BIAS    = HALF_TURN + 46 * TURN;

   // CORDIC: 16 rotations, Q30 start value carries the inverse gain
   localparam int unsigned CORDIC_STEPS = 16;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
   localparam int unsigned ONE_Q14 = 16384;

   // Command into the shared root / divide unit
   typedef struct packed {
      logic start;
      logic is_div;
   } fpc_rd_cmd_type;

   // Arctangent of 2^-i in 1/32768 degree
   function automatic logic signed [24:0] atan_lut(input logic [3:0] idx);
      logic signed [24:0] v;
      unique case (idx)
         4'd0:  v = 25'sd1474560;
         4'd1:  v = 25'sd870484;
         4'd2:  v = 25'sd459940;
         4'd3:  v = 25'sd233473;
         4'd4:  v = 25'sd117189;
         4'd5:  v = 25'sd58652;
         4'd6:  v = 25'sd29333;
         4'd7:  v = 25'sd14667;
         4'd8:  v = 25'sd7334;
         4'd9:  v = 25'sd3667;
         4'd10: v = 25'sd1833;
         4'd11: v = 25'sd917;
         4'd12: v = 25'sd458;
         4'd13: v = 25'sd229;
         4'd14: v = 25'sd115;
         4'd15: v = 25'sd57;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/fpc_root_div.sv
// Shared iterative unit: 64-bit floor square root (32 steps) and the
// Q1.14 unit divide round(mag*16384/len) clamped to 16384 (16 steps).
// Depends on fpc_pkg.
module fpc_root_div (
   input  logic                   clock,
   input  logic                   reset,
   input  fpc_pkg::fpc_rd_cmd_type cmd,
   input  logic [63:0]            radicand,
   input  logic [31:0]            numer_mag,
   input  logic [31:0]            divisor,
   output logic                   done,
   output logic [31:0]            result
);

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [31:0] dsr_ff, dsr_in;

   logic [46:0] numer;
   logic [63:0] trial;
   logic [32:0] part;
   logic [15:0] quo;

   // Next state of the unit
   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      dsr_in  = dsr_ff;
      numer   = {1'b0, numer_mag, 14'd0} + 47'(divisor >> 1);
      trial   = res_ff + bit_ff;
      part    = {res_ff[31:0], n_ff[63]};
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         dsr_in  = divisor;
         bit_in  = 64'd1 << 62;
         if (cmd.is_div) begin
            // upper bits are below the divisor, so 16 quotient bits suffice
            cnt_in = 5'd15;
            res_in = 64'(numer[46:16]);
            n_in   = {numer[15:0], 48'd0};
         end else begin
            cnt_in = 5'd31;
            res_in = 64'd0;
            n_in   = radicand;
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            // restoring divide: numerator bits leave the top, quotient enters below
            if (part >= {1'b0, dsr_ff}) begin
               res_in = 64'(part - {1'b0, dsr_ff});
               n_in   = {n_ff[62:0], 1'b1};
            end else begin
               res_in = 64'(part);
               n_in   = {n_ff[62:0], 1'b0};
            end
         end else begin
            // digit-by-digit square root
            if (n_ff >= trial) begin
               n_in   = n_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      dsr_ff <= dsr_in;
   end

   // Result select with unit-length clamp on the quotient
   always_comb begin
      quo = n_ff[15:0];
      if (quo > 16'(fpc_pkg::ONE_Q14)) quo = 16'(fpc_pkg::ONE_Q14);
      result = div_ff ? 32'(quo) : res_ff[31:0];
   end

   assign done = done_ff;

endmodule

### rtl/first_person_camera_update_unit.sv
// Top level of the fly camera update block: sequencer, state and datapath.
// Depends on fpc_pkg and fpc_root_div.
//
// Fly camera with Q16.16 position, yaw and pitch in 1/128 degree and a Q1.14
// unit view direction. One item is handled at a time; req_ready is high only
// while the sequencer is idle. A mouse item takes 7 wrap steps, two 16-step
// CORDIC passes, one 32-step square root and three 16-step divides. A key
// item takes six cross products, the root and divides for the strafe vector,
// and a move step for each held key. The work is done by the CORDIC loop and
// the shared root / divide unit, plus one registered 33x33 multiplier used for
// every product. The result sits in an output register, so the next item is
// taken while it waits.
module first_person_camera_update_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [3:0]         req_keys_held,
   input  logic [15:0]        req_delta_time,
   input  logic signed [11:0] req_x_offset,
   input  logic signed [11:0] req_y_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [15:0] rsp_front_x,
   output logic signed [15:0] rsp_front_y,
   output logic signed [15:0] rsp_front_z,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   // Register indexes
   localparam logic [2:0] CSR_SPEED = 3'd0;
   localparam logic [2:0] CSR_SENS  = 3'd1;
   localparam logic [2:0] CSR_UP_X  = 3'd2;
   localparam logic [2:0] CSR_UP_Y  = 3'd3;
   localparam logic [2:0] CSR_UP_Z  = 3'd4;

   // Sequencer states
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_MY_MUL   = 5'd1;
   localparam logic [4:0] ST_MY_ADD   = 5'd2;
   localparam logic [4:0] ST_MP_MUL   = 5'd3;
   localparam logic [4:0] ST_MP_ADD   = 5'd4;
   localparam logic [4:0] ST_WRAP     = 5'd5;
   localparam logic [4:0] ST_WRAP_END = 5'd6;
   localparam logic [4:0] ST_CINIT    = 5'd7;
   localparam logic [4:0] ST_CITER    = 5'd8;
   localparam logic [4:0] ST_C_END    = 5'd9;
   localparam logic [4:0] ST_D_MUL    = 5'd10;
   localparam logic [4:0] ST_D_RND    = 5'd11;
   localparam logic [4:0] ST_K_MUL    = 5'd12;
   localparam logic [4:0] ST_K_SCL    = 5'd13;
   localparam logic [4:0] ST_CR_MUL   = 5'd14;
   localparam logic [4:0] ST_CR_ACC   = 5'd15;
   localparam logic [4:0] ST_SQ_MUL   = 5'd16;
   localparam logic [4:0] ST_SQ_ACC   = 5'd17;
   localparam logic [4:0] ST_RT_GO    = 5'd18;
   localparam logic [4:0] ST_RT_WAIT  = 5'd19;
   localparam logic [4:0] ST_DV_GO    = 5'd20;
   localparam logic [4:0] ST_DV_WAIT  = 5'd21;
   localparam logic [4:0] ST_MV_CHK   = 5'd22;
   localparam logic [4:0] ST_MV_MUL   = 5'd23;
   localparam logic [4:0] ST_MV_ADD   = 5'd24;
   localparam logic [4:0] ST_DONE     = 5'd25;

   // Move order: D, A, W, S
   localparam logic [1:0] MV_D = 2'd0;
   localparam logic [1:0] MV_A = 2'd1;
   localparam logic [1:0] MV_W = 2'd2;
   localparam logic [1:0] MV_S = 2'd3;

   localparam logic [1:0] LAST_K = 2'd2;

   // round half away from zero, shift by 30
   function automatic logic signed [33:0] rnd30(input logic signed [65:0] v);
      logic [65:0] mag;
      logic [65:0] r;
      mag = v[65] ? 66'(-v) : 66'(v);
      r   = (mag + (66'd1 << 29)) >> 30;
      return v[65] ? -34'(r) : 34'(r);
   endfunction

   // round half away from zero, shift by 22
   function automatic logic signed [25:0] rnd22(input logic signed [65:0] v);
      logic [65:0] mag;
      logic [65:0] r;
      mag = v[65] ? 66'(-v) : 66'(v);
      r   = (mag + (66'd1 << 21)) >> 22;
      return v[65] ? -26'(r) : 26'(r);
   endfunction

   // Control and configuration
   logic [4:0]  state_ff, state_in;
   logic [15:0] speed_ff, speed_in;
   logic [9:0]  sens_ff, sens_in;
   logic signed [15:0] up_ff [3];
   logic signed [15:0] up_in [3];

   // Latched item
   logic        path_ff, path_in;
   logic [3:0]  keys_ff, keys_in;
   logic [15:0] dt_ff, dt_in;
   logic signed [11:0] xo_ff, xo_in;
   logic signed [11:0] yo_ff, yo_in;

   // Camera state
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [15:0] yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic signed [16:0] front_ff [3];
   logic signed [16:0] front_in [3];

   // Work registers
   logic signed [16:0] side_ff [3];
   logic signed [16:0] side_in [3];
   logic               have_side_ff, have_side_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [33:0] acc_ff, acc_in;
   logic signed [33:0] vec_ff [3];
   logic signed [33:0] vec_in [3];
   logic [63:0] sum_ff, sum_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] scale_ff, scale_in;
   logic [22:0] wrap_ff, wrap_in;
   logic signed [33:0] cx_ff, cx_in;
   logic signed [33:0] cy_ff, cy_in;
   logic signed [24:0] cz_ff, cz_in;
   logic        cneg_ff, cneg_in;
   logic        csel_ff, csel_in;
   logic signed [33:0] cosy_ff, cosy_in;
   logic signed [33:0] siny_ff, siny_in;
   logic signed [33:0] cosp_ff, cosp_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [1:0]  k_ff, k_in;
   logic [1:0]  mv_ff, mv_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic signed [31:0] out_pos_ff [3];
   logic signed [31:0] out_pos_in [3];
   logic signed [15:0] out_front_ff [3];
   logic signed [15:0] out_front_in [3];

   // Shared multiplier operands
   logic signed [32:0] mul_a, mul_b;

   // Root / divide unit
   fpc_pkg::fpc_rd_cmd_type rd_cmd;
   logic        rd_done;
   logic [31:0] rd_result;
   logic [33:0] vec_mag;

   // Scratch
   logic signed [24:0] ytmp;
   logic signed [23:0] ptmp;
   logic [22:0]        wlim;
   logic signed [16:0] ang;
   logic signed [33:0] xs, ys, xf, yf;
   logic signed [24:0] at;
   logic signed [16:0] qs;
   logic               mv_en, mv_sub;
   logic signed [25:0] dmv;
   logic signed [33:0] psum;

   assign vec_mag = vec_ff[k_ff][33] ? 34'(-vec_ff[k_ff]) : 34'(vec_ff[k_ff]);

   fpc_root_div u_root_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rd_cmd),
      .radicand  (sum_ff),
      .numer_mag (vec_mag[31:0]),
      .divisor   (len_ff),
      .done      (rd_done),
      .result    (rd_result)
   );

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MY_MUL: begin
            mul_a = 33'(xo_ff);
            mul_b = 33'(sens_ff);
         end
         ST_MP_MUL: begin
            mul_a = 33'(yo_ff);
            mul_b = 33'(sens_ff);
         end
         ST_K_MUL: begin
            mul_a = 33'(speed_ff);
            mul_b = 33'(dt_ff);
         end
         ST_CR_MUL: begin
            case (cnt_ff)
               4'd0: begin mul_a = 33'(up_ff[1]); mul_b = 33'(front_ff[2]); end
               4'd1: begin mul_a = 33'(up_ff[2]); mul_b = 33'(front_ff[1]); end
               4'd2: begin mul_a = 33'(up_ff[2]); mul_b = 33'(front_ff[0]); end
               4'd3: begin mul_a = 33'(up_ff[0]); mul_b = 33'(front_ff[2]); end
               4'd4: begin mul_a = 33'(up_ff[0]); mul_b = 33'(front_ff[1]); end
               default: begin mul_a = 33'(up_ff[1]); mul_b = 33'(front_ff[0]); end
            endcase
         end
         ST_D_MUL: begin
            mul_a = (k_ff == 2'd0) ? cosy_ff[32:0] : siny_ff[32:0];
            mul_b = cosp_ff[32:0];
         end
         ST_SQ_MUL: begin
            mul_a = vec_ff[k_ff][32:0];
            mul_b = vec_ff[k_ff][32:0];
         end
         ST_MV_MUL: begin
            mul_a = (mv_ff == MV_D || mv_ff == MV_A) ? 33'(side_ff[k_ff])
                                                    : 33'(front_ff[k_ff]);
            mul_b = signed'(scale_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 66'(mul_a) * 66'(mul_b);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      speed_in     = speed_ff;
      sens_in      = sens_ff;
      up_in        = up_ff;
      path_in      = path_ff;
      keys_in      = keys_ff;
      dt_in        = dt_ff;
      xo_in        = xo_ff;
      yo_in        = yo_ff;
      pos_in       = pos_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      front_in     = front_ff;
      side_in      = side_ff;
      have_side_in = have_side_ff;
      acc_in       = acc_ff;
      vec_in       = vec_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      scale_in     = scale_ff;
      wrap_in      = wrap_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      cneg_in      = cneg_ff;
      csel_in      = csel_ff;
      cosy_in      = cosy_ff;
      siny_in      = siny_ff;
      cosp_in      = cosp_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      mv_in        = mv_ff;
      out_valid_in = out_valid_ff;
      out_pos_in   = out_pos_ff;
      out_front_in = out_front_ff;
      rd_cmd       = '0;

      ytmp   = '0;
      ptmp   = '0;
      wlim   = '0;
      ang    = '0;
      xs     = '0;
      ys     = '0;
      xf     = '0;
      yf     = '0;
      at     = '0;
      qs     = '0;
      mv_en  = 1'b0;
      mv_sub = 1'b0;
      dmv    = '0;
      psum   = '0;

      // result taken
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED: speed_in = csr_wdata;
            CSR_SENS:  sens_in  = csr_wdata[9:0];
            CSR_UP_X:  up_in[0] = signed'(csr_wdata);
            CSR_UP_Y:  up_in[1] = signed'(csr_wdata);
            CSR_UP_Z:  up_in[2] = signed'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               path_in = req_kind;
               keys_in = req_keys_held;
               dt_in   = req_delta_time;
               xo_in   = req_x_offset;
               yo_in   = req_y_offset;
               sum_in  = '0;
               state_in = req_kind ? ST_MY_MUL : ST_K_MUL;
            end
         end

         // yaw + step, biased nonnegative
         ST_MY_MUL: state_in = ST_MP_MUL;
         ST_MP_MUL: begin
            ytmp = 25'(yaw_ff) + 25'(signed'(prod_ff[22:0]))
                 + 25'(fpc_pkg::WRAP_BIAS);
            wrap_in  = ytmp[22:0];
            state_in = ST_MP_ADD;
         end
         // pitch + step, clamped
         ST_MP_ADD: begin
            ptmp = 24'(pitch_ff) + 24'(signed'(prod_ff[22:0]));
            if (ptmp > signed'(24'(fpc_pkg::PITCH_LIMIT)))
               ptmp = signed'(24'(fpc_pkg::PITCH_LIMIT));
            else if (ptmp < -signed'(24'(fpc_pkg::PITCH_LIMIT)))
               ptmp = -signed'(24'(fpc_pkg::PITCH_LIMIT));
            pitch_in = ptmp[14:0];
            cnt_in   = 4'd6;
            state_in = ST_WRAP;
         end
         // modulo one turn by shifted subtraction
         ST_WRAP: begin
            wlim = 23'(fpc_pkg::TURN) << cnt_ff;
            if (wrap_ff >= wlim) wrap_in = wrap_ff - wlim;
            if (cnt_ff == 4'd0) state_in = ST_WRAP_END;
            else cnt_in = cnt_ff - 4'd1;
         end
         ST_WRAP_END: begin
            yaw_in   = signed'(16'(wrap_ff - 23'(fpc_pkg::HALF_TURN)));
            csel_in  = 1'b0;
            state_in = ST_CINIT;
         end

         // fold into +-90 deg and start a rotation
         ST_CINIT: begin
            ang = csel_ff ? 17'(pitch_ff) : 17'(yaw_ff);
            cneg_in = 1'b0;
            if (ang > 17'sd11520) begin
               ang = ang - 17'(fpc_pkg::HALF_TURN);
               cneg_in = 1'b1;
            end else if (ang < -17'sd11520) begin
               ang = ang + 17'(fpc_pkg::HALF_TURN);
               cneg_in = 1'b1;
            end
            cz_in    = signed'({ang, 8'd0});
            cx_in    = fpc_pkg::CORDIC_GAIN;
            cy_in    = '0;
            cnt_in   = '0;
            state_in = ST_CITER;
         end
         ST_CITER: begin
            xs = cx_ff >>> cnt_ff;
            ys = cy_ff >>> cnt_ff;
            at = fpc_pkg::atan_lut(cnt_ff);
            if (!cz_ff[24]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
            if (cnt_ff == 4'(fpc_pkg::CORDIC_STEPS - 1)) state_in = ST_C_END;
            else cnt_in = cnt_ff + 4'd1;
         end
         ST_C_END: begin
            xf = cneg_ff ? -cx_ff : cx_ff;
            yf = cneg_ff ? -cy_ff : cy_ff;
            if (!csel_ff) begin
               cosy_in  = xf;
               siny_in  = yf;
               csel_in  = 1'b1;
               state_in = ST_CINIT;
            end else begin
               cosp_in   = xf;
               vec_in[1] = yf;
               csel_in   = 1'b0;
               k_in      = 2'd0;
               state_in  = ST_D_MUL;
            end
         end
         // horizontal components scaled by cos pitch
         ST_D_MUL: state_in = ST_D_RND;
         ST_D_RND: begin
            vec_in[k_ff] = rnd30(prod_ff);
            if (k_ff == 2'd0) begin
               k_in     = LAST_K;
               state_in = ST_D_MUL;
            end else begin
               k_in     = 2'd0;
               state_in = ST_SQ_MUL;
            end
         end

         // key item: speed * dt
         ST_K_MUL: state_in = ST_K_SCL;
         ST_K_SCL: begin
            scale_in = prod_ff[32:0];
            cnt_in   = '0;
            state_in = ST_CR_MUL;
         end
         // cross(up, front), one product per pass
         ST_CR_MUL: state_in = ST_CR_ACC;
         ST_CR_ACC: begin
            if (!cnt_ff[0]) acc_in = prod_ff[33:0];
            else vec_in[cnt_ff[2:1]] = acc_ff - prod_ff[33:0];
            if (cnt_ff == 4'd5) begin
               k_in     = 2'd0;
               state_in = ST_SQ_MUL;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = ST_CR_MUL;
            end
         end

         // squared length
         ST_SQ_MUL: state_in = ST_SQ_ACC;
         ST_SQ_ACC: begin
            sum_in = sum_ff + prod_ff[63:0];
            if (k_ff == LAST_K) begin
               k_in     = 2'd0;
               state_in = ST_RT_GO;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_RT_GO: begin
            rd_cmd.start  = 1'b1;
            rd_cmd.is_div = 1'b0;
            state_in      = ST_RT_WAIT;
         end
         ST_RT_WAIT: begin
            if (rd_done) begin
               len_in = rd_result;
               if (rd_result == 32'd0) begin
                  // zero length: front kept, or no strafe
                  have_side_in = 1'b0;
                  mv_in        = MV_D;
                  state_in     = path_ff ? ST_DONE : ST_MV_CHK;
               end else begin
                  have_side_in = 1'b1;
                  k_in         = 2'd0;
                  state_in     = ST_DV_GO;
               end
            end
         end
         // normalize each component
         ST_DV_GO: begin
            rd_cmd.start  = 1'b1;
            rd_cmd.is_div = 1'b1;
            state_in      = ST_DV_WAIT;
         end
         ST_DV_WAIT: begin
            if (rd_done) begin
               qs = vec_ff[k_ff][33] ? -17'(rd_result[15:0]) : 17'(rd_result[15:0]);
               if (path_ff) front_in[k_ff] = qs;
               else side_in[k_ff] = qs;
               if (k_ff == LAST_K) begin
                  k_in     = 2'd0;
                  mv_in    = MV_D;
                  state_in = path_ff ? ST_DONE : ST_MV_CHK;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_DV_GO;
               end
            end
         end

         // moves in order D, A, W, S
         ST_MV_CHK: begin
            case (mv_ff)
               MV_D:    mv_en = keys_ff[3] & have_side_ff;
               MV_A:    mv_en = keys_ff[2] & have_side_ff;
               MV_W:    mv_en = keys_ff[0];
               default: mv_en = keys_ff[1];
            endcase
            if (mv_en) begin
               k_in     = 2'd0;
               state_in = ST_MV_MUL;
            end else if (mv_ff == MV_S) begin
               state_in = ST_DONE;
            end else begin
               mv_in = mv_ff + 2'd1;
            end
         end
         ST_MV_MUL: state_in = ST_MV_ADD;
         ST_MV_ADD: begin
            mv_sub = (mv_ff == MV_D) || (mv_ff == MV_S);
            dmv    = rnd22(prod_ff);
            if (mv_sub) dmv = -dmv;
            psum = 34'(pos_ff[k_ff]) + 34'(dmv);
            if (psum > 34'sd2147483647) pos_in[k_ff] = 32'sh7FFFFFFF;
            else if (psum < -34'sd2147483648) pos_in[k_ff] = 32'sh80000000;
            else pos_in[k_ff] = psum[31:0];
            if (k_ff == LAST_K) begin
               k_in = 2'd0;
               if (mv_ff == MV_S) state_in = ST_DONE;
               else begin
                  mv_in    = mv_ff + 2'd1;
                  state_in = ST_MV_CHK;
               end
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_MV_MUL;
            end
         end

         // hand the item's result to the output register
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  out_pos_in[i]   = pos_ff[i];
                  out_front_in[i] = front_ff[i][15:0];
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         speed_ff     <= 16'd640;
         sens_ff      <= 10'd13;
         up_ff[0]     <= 16'sd0;
         up_ff[1]     <= 16'sd16384;
         up_ff[2]     <= 16'sd0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         pos_ff[2]    <= '0;
         yaw_ff       <= -16'sd11520;
         pitch_ff     <= '0;
         front_ff[0]  <= '0;
         front_ff[1]  <= '0;
         front_ff[2]  <= -17'sd16384;
         csel_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         speed_ff     <= speed_in;
         sens_ff      <= sens_in;
         up_ff        <= up_in;
         pos_ff       <= pos_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         front_ff     <= front_in;
         csel_ff      <= csel_in;
      end
      path_ff      <= path_in;
      keys_ff      <= keys_in;
      dt_ff        <= dt_in;
      xo_ff        <= xo_in;
      yo_ff        <= yo_in;
      side_ff      <= side_in;
      have_side_ff <= have_side_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      vec_ff       <= vec_in;
      sum_ff       <= sum_in;
      len_ff       <= len_in;
      scale_ff     <= scale_in;
      wrap_ff      <= wrap_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      cneg_ff      <= cneg_in;
      cosy_ff      <= cosy_in;
      siny_ff      <= siny_in;
      cosp_ff      <= cosp_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      mv_ff        <= mv_in;
      out_pos_ff   <= out_pos_in;
      out_front_ff <= out_front_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = out_valid_ff;
   assign rsp_pos_x   = out_pos_ff[0];
   assign rsp_pos_y   = out_pos_ff[1];
   assign rsp_pos_z   = out_pos_ff[2];
   assign rsp_front_x = out_front_ff[0];
   assign rsp_front_y = out_front_ff[1];
   assign rsp_front_z = out_front_ff[2];

endmodule

### rtl/fpc_checker.sv
// Port-level checks for the fly camera update block, bound to the top level.
// Depends only on the top level's ports.
module fpc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_pos_x,
   input logic signed [15:0] rsp_front_x,
   input logic signed [15:0] rsp_front_y,
   input logic signed [15:0] rsp_front_z
);

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // one item at a time: accepting an item drops ready
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while busy");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)
                                     && $stable(rsp_front_z)))
      else $error("result changed while stalled");

   // each view direction component stays within +-1.0 in Q1.14
   a_front_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_front_x >= -16'sd16384 && rsp_front_x <= 16'sd16384
                     && rsp_front_y >= -16'sd16384 && rsp_front_y <= 16'sd16384
                     && rsp_front_z >= -16'sd16384 && rsp_front_z <= 16'sd16384))
      else $error("front component out of range");

endmodule

bind first_person_camera_update_unit fpc_checker u_fpc_checker (.*);
